>>> rtl/mrc_pkg.sv
// ----------------------------------------------------------------------------
// mrc_pkg
// Shared types, constants and codes for the Modbus request checker.
// ----------------------------------------------------------------------------
`default_nettype none

package mrc_pkg;

  // Protocol length limits
  localparam int MAX_PDU_DATA    = 252;
  localparam int MAX_MBAP_LENGTH = 260;
  localparam int ADU_LIMIT       = 256;

  // Depth of the queue between classifier and checker
  localparam int QUEUE_DEPTH_DEF = 2;

  // Configuration register widths
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  // Function codes
  localparam logic [7:0] FC_READ_COILS      = 8'd1;
  localparam logic [7:0] FC_READ_DISCRETE   = 8'd2;
  localparam logic [7:0] FC_READ_HOLDING    = 8'd3;
  localparam logic [7:0] FC_READ_INPUT      = 8'd4;
  localparam logic [7:0] FC_WRITE_COIL      = 8'd5;
  localparam logic [7:0] FC_WRITE_REG       = 8'd6;
  localparam logic [7:0] FC_WRITE_COILS     = 8'd15;
  localparam logic [7:0] FC_WRITE_REGS      = 8'd16;

  // Single coil values
  localparam logic [15:0] COIL_OFF = 16'h0000;
  localparam logic [15:0] COIL_ON  = 16'hFF00;

  // Register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MAX_ADDRESS   = 3'd0,
    CFG_MIN_SLAVE_ID  = 3'd1,
    CFG_MAX_SLAVE_ID  = 3'd2,
    CFG_MIN_QUANTITY  = 3'd3,
    CFG_MAX_RD_BITS   = 3'd4,
    CFG_MAX_RD_REGS   = 3'd5,
    CFG_MAX_WR_COILS  = 3'd6,
    CFG_MAX_WR_REGS   = 3'd7
  } cfg_idx_e;

  // Error codes
  typedef enum logic [4:0] {
    ERR_OK             = 5'd0,
    ERR_SLAVE_ID       = 5'd1,
    ERR_PDU_LEN        = 5'd2,
    ERR_RD_LEN         = 5'd3,
    ERR_RD_QTY_MIN     = 5'd4,
    ERR_RD_RANGE       = 5'd5,
    ERR_RD_BITS_MAX    = 5'd6,
    ERR_RD_REGS_MAX    = 5'd7,
    ERR_WS_LEN         = 5'd8,
    ERR_WS_ADDR        = 5'd9,
    ERR_WS_COIL_VAL    = 5'd10,
    ERR_WM_LEN         = 5'd11,
    ERR_WM_QTY_MIN     = 5'd12,
    ERR_WM_RANGE       = 5'd13,
    ERR_WM_BC_LEN      = 5'd14,
    ERR_WM_COILS_MAX   = 5'd15,
    ERR_WM_COIL_BC     = 5'd16,
    ERR_WM_REGS_MAX    = 5'd17,
    ERR_WM_REG_BC      = 5'd18,
    ERR_FUNC           = 5'd19,
    ERR_MBAP_LEN       = 5'd20,
    ERR_ADU_LEN        = 5'd21
  } err_e;

  // Request class as sorted by the front end
  typedef enum logic [2:0] {
    CLS_READ_BITS,
    CLS_READ_REGS,
    CLS_WRITE_COIL,
    CLS_WRITE_REG,
    CLS_MULTI_COILS,
    CLS_MULTI_REGS,
    CLS_UNSUPPORTED
  } cls_e;

  // Input item
  typedef struct packed {
    logic        rtu_mode;
    logic [7:0]  slave_id;
    logic [7:0]  function_code;
    logic [9:0]  data_length;
    logic [15:0] start_address;
    logic [15:0] quantity_or_value;
    logic [7:0]  byte_count;
  } req_t;

  // Result item
  typedef struct packed {
    logic       valid_res;
    logic [4:0] error_code;
  } rsp_t;

  // Configuration registers
  typedef struct packed {
    logic [15:0] max_address;
    logic [7:0]  min_slave_id;
    logic [7:0]  max_slave_id;
    logic [15:0] min_quantity;
    logic [15:0] max_read_bits;
    logic [15:0] max_read_registers;
    logic [15:0] max_write_coils;
    logic [15:0] max_write_registers;
  } cfg_t;

  // Classified request held in the queue
  typedef struct packed {
    cls_e        cls;
    logic        slave_err;
    logic        len_err;
    logic        len_is4;
    logic        len_ge5;
    logic        mbap_err;
    logic        adu_err;
    logic [15:0] start_address;
    logic [15:0] qty;
    logic [16:0] range_end;
    logic        bc_len_ok;
    logic        coil_bc_ok;
    logic        reg_bc_ok;
  } cls_t;

endpackage

`default_nettype wire

>>> rtl/modbus_request_checker_unit.sv
// ----------------------------------------------------------------------------
// modbus_request_checker_unit
// An accepted item enters the QueueDepth-entry FIFO between classifier and
// checker, then its result is registered. Throughput: one item per cycle
// while out_stall_i is low; the output register refills while it is taken.
// Reset: limit registers return to their defaults, FIFO and output empty.
// ----------------------------------------------------------------------------
`default_nettype none

module modbus_request_checker_unit import mrc_pkg::*; #(
  parameter int QueueDepth = QUEUE_DEPTH_DEF
) (
  input  var logic                  clk_i,
  input  var logic                  rst_ni,
  input  var logic                  cfg_we_i,
  input  var logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  var logic [CFG_DATA_W-1:0] cfg_data_i,
  input  var logic                  in_valid_i,
  output logic                      in_stall_o,
  input  var req_t                  in_req_i,
  output logic                      out_valid_o,
  input  var logic                  out_stall_i,
  output rsp_t                      out_rsp_o
);

  cfg_t cfg_q;
  cls_t front_cls;
  cls_t q_data;
  logic q_valid;
  logic q_ready;

  // Limit registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.max_address         <= 16'd65535;
      cfg_q.min_slave_id        <= 8'd1;
      cfg_q.max_slave_id        <= 8'd247;
      cfg_q.min_quantity        <= 16'd1;
      cfg_q.max_read_bits       <= 16'd2000;
      cfg_q.max_read_registers  <= 16'd125;
      cfg_q.max_write_coils     <= 16'd1968;
      cfg_q.max_write_registers <= 16'd123;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_MAX_ADDRESS:  cfg_q.max_address         <= cfg_data_i;
        CFG_MIN_SLAVE_ID: cfg_q.min_slave_id        <= cfg_data_i[7:0];
        CFG_MAX_SLAVE_ID: cfg_q.max_slave_id        <= cfg_data_i[7:0];
        CFG_MIN_QUANTITY: cfg_q.min_quantity        <= cfg_data_i;
        CFG_MAX_RD_BITS:  cfg_q.max_read_bits       <= cfg_data_i;
        CFG_MAX_RD_REGS:  cfg_q.max_read_registers  <= cfg_data_i;
        CFG_MAX_WR_COILS: cfg_q.max_write_coils     <= cfg_data_i;
        CFG_MAX_WR_REGS:  cfg_q.max_write_registers <= cfg_data_i;
        default:          cfg_q                     <= cfg_q;
      endcase
    end
  end

  mrc_front u_front (
    .req_i (in_req_i),
    .cfg_i (cfg_q),
    .cls_o (front_cls)
  );

  mrc_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (in_valid_i),
    .push_stall_o (in_stall_o),
    .push_data_i  (front_cls),
    .pop_valid_o  (q_valid),
    .pop_ready_i  (q_ready),
    .pop_data_o   (q_data)
  );

  mrc_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .q_valid_i   (q_valid),
    .q_ready_o   (q_ready),
    .q_data_i    (q_data),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_rsp_o   (out_rsp_o)
  );

endmodule

`default_nettype wire

>>> rtl/mrc_front.sv
// ----------------------------------------------------------------------------
// mrc_front
// Classifies a request header and precomputes its length, range and
// byte-count checks for the back end.
// ----------------------------------------------------------------------------
`default_nettype none

module mrc_front import mrc_pkg::*; (
  input  var req_t req_i,
  input  var cfg_t cfg_i,
  output cls_t     cls_o
);

  logic [9:0]  len_m5;
  logic [16:0] coil_bytes;
  logic [16:0] reg_bytes;
  logic [10:0] len_x;

  assign len_x      = {1'b0, req_i.data_length};
  assign len_m5     = req_i.data_length - 10'd5;
  assign coil_bytes = ({1'b0, req_i.quantity_or_value} + 17'd7) >> 3;
  assign reg_bytes  = {req_i.quantity_or_value, 1'b0};

  // Function code sort
  always_comb begin
    case (req_i.function_code)
      FC_READ_COILS, FC_READ_DISCRETE: cls_o.cls = CLS_READ_BITS;
      FC_READ_HOLDING, FC_READ_INPUT:  cls_o.cls = CLS_READ_REGS;
      FC_WRITE_COIL:                   cls_o.cls = CLS_WRITE_COIL;
      FC_WRITE_REG:                    cls_o.cls = CLS_WRITE_REG;
      FC_WRITE_COILS:                  cls_o.cls = CLS_MULTI_COILS;
      FC_WRITE_REGS:                   cls_o.cls = CLS_MULTI_REGS;
      default:                         cls_o.cls = CLS_UNSUPPORTED;
    endcase
  end

  // Header-level checks
  assign cls_o.slave_err = req_i.rtu_mode &&
                           ((req_i.slave_id < cfg_i.min_slave_id) ||
                            (req_i.slave_id > cfg_i.max_slave_id));
  assign cls_o.len_err   = req_i.data_length > 10'(MAX_PDU_DATA);
  assign cls_o.len_is4   = req_i.data_length == 10'd4;
  assign cls_o.len_ge5   = req_i.data_length >= 10'd5;
  assign cls_o.mbap_err  = (len_x + 11'd2) > 11'(MAX_MBAP_LENGTH);
  assign cls_o.adu_err   = (len_x + 11'd4) > 11'(ADU_LIMIT);

  // Range end without wrap; zero quantity is caught in the back end
  assign cls_o.start_address = req_i.start_address;
  assign cls_o.qty           = req_i.quantity_or_value;
  assign cls_o.range_end     = {1'b0, req_i.start_address}
                             + {1'b0, req_i.quantity_or_value} - 17'd1;

  // Byte count against actual and expected lengths
  assign cls_o.bc_len_ok  = {2'b00, req_i.byte_count} == len_m5;
  assign cls_o.coil_bc_ok = {9'd0, req_i.byte_count} == coil_bytes;
  assign cls_o.reg_bc_ok  = {9'd0, req_i.byte_count} == reg_bytes;

endmodule

`default_nettype wire

>>> rtl/mrc_queue.sv
// ----------------------------------------------------------------------------
// mrc_queue
// Short FIFO of classified items between the front and back ends.
// ----------------------------------------------------------------------------
`default_nettype none

module mrc_queue import mrc_pkg::*; #(
  parameter int Depth = QUEUE_DEPTH_DEF
) (
  input  var logic clk_i,
  input  var logic rst_ni,
  input  var logic push_valid_i,
  output logic     push_stall_o,
  input  var cls_t push_data_i,
  output logic     pop_valid_o,
  input  var logic pop_ready_i,
  output cls_t     pop_data_o
);

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);

  cls_t            mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            push, pop;

  assign push_stall_o = cnt_q == CntW'(Depth);
  assign pop_valid_o  = cnt_q != '0;
  assign pop_data_o   = mem_q[rd_ptr_q];
  assign push         = push_valid_i && !push_stall_o;
  assign pop          = pop_valid_o && pop_ready_i;

  // Pointer and fill count update
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    case ({push, pop})
      2'b10:   cnt_d = cnt_q + 1'b1;
      2'b01:   cnt_d = cnt_q - 1'b1;
      default: cnt_d = cnt_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // Storage, no reset
  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

`default_nettype wire

>>> rtl/mrc_back.sv
// ----------------------------------------------------------------------------
// mrc_back
// Applies the quantity limits and rule order to a classified item and
// holds the result in an output register.
// ----------------------------------------------------------------------------
`default_nettype none

module mrc_back import mrc_pkg::*; (
  input  var logic clk_i,
  input  var logic rst_ni,
  input  var cfg_t cfg_i,
  input  var logic q_valid_i,
  output logic     q_ready_o,
  input  var cls_t q_data_i,
  output logic     out_valid_o,
  input  var logic out_stall_i,
  output rsp_t     out_rsp_o
);

  logic out_valid_q, out_valid_d;
  rsp_t out_rsp_q;
  err_e err;
  logic range_ok;
  logic pop;

  assign range_ok = (q_data_i.qty != 16'd0) &&
                    (q_data_i.range_end <= {1'b0, cfg_i.max_address});

  // Rule order: header, per-class rules, then ADU limits
  always_comb begin
    err = ERR_OK;
    if (q_data_i.slave_err) begin
      err = ERR_SLAVE_ID;
    end else if (q_data_i.len_err) begin
      err = ERR_PDU_LEN;
    end else begin
      case (q_data_i.cls)
        CLS_READ_BITS, CLS_READ_REGS: begin
          if (!q_data_i.len_is4)                          err = ERR_RD_LEN;
          else if (q_data_i.qty < cfg_i.min_quantity)     err = ERR_RD_QTY_MIN;
          else if (!range_ok)                             err = ERR_RD_RANGE;
          else if (q_data_i.cls == CLS_READ_BITS &&
                   q_data_i.qty > cfg_i.max_read_bits)    err = ERR_RD_BITS_MAX;
          else if (q_data_i.cls == CLS_READ_REGS &&
                   q_data_i.qty > cfg_i.max_read_registers) err = ERR_RD_REGS_MAX;
        end
        CLS_WRITE_COIL, CLS_WRITE_REG: begin
          if (!q_data_i.len_is4) err = ERR_WS_LEN;
          else if (q_data_i.start_address > cfg_i.max_address) err = ERR_WS_ADDR;
          else if (q_data_i.cls == CLS_WRITE_COIL &&
                   q_data_i.qty != COIL_OFF && q_data_i.qty != COIL_ON)
            err = ERR_WS_COIL_VAL;
        end
        CLS_MULTI_COILS, CLS_MULTI_REGS: begin
          if (!q_data_i.len_ge5)                          err = ERR_WM_LEN;
          else if (q_data_i.qty < cfg_i.min_quantity)     err = ERR_WM_QTY_MIN;
          else if (!range_ok)                             err = ERR_WM_RANGE;
          else if (!q_data_i.bc_len_ok)                   err = ERR_WM_BC_LEN;
          else if (q_data_i.cls == CLS_MULTI_COILS) begin
            if (q_data_i.qty > cfg_i.max_write_coils)     err = ERR_WM_COILS_MAX;
            else if (!q_data_i.coil_bc_ok)                err = ERR_WM_COIL_BC;
          end else begin
            if (q_data_i.qty > cfg_i.max_write_registers) err = ERR_WM_REGS_MAX;
            else if (!q_data_i.reg_bc_ok)                 err = ERR_WM_REG_BC;
          end
        end
        default: err = ERR_FUNC;
      endcase
      if (err == ERR_OK) begin
        if (q_data_i.mbap_err)     err = ERR_MBAP_LEN;
        else if (q_data_i.adu_err) err = ERR_ADU_LEN;
      end
    end
  end

  // Output register: refill whenever empty or being taken
  assign q_ready_o   = !out_valid_q || !out_stall_i;
  assign pop         = q_valid_i && q_ready_o;
  assign out_valid_d = pop ? 1'b1 : (out_valid_q && out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop) begin
      out_rsp_q.valid_res  <= err == ERR_OK;
      out_rsp_q.error_code <= err;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = out_rsp_q;

endmodule

`default_nettype wire

>>> dv/modbus_request_checker_unit_tb.sv
// ----------------------------------------------------------------------------
// modbus_request_checker_unit_tb
// Self-checking bench for the Modbus request header checker. Request items
// are driven through the valid/stall input channel from a pending queue, and
// each one's outcome code is predicted from a local copy of the limit
// registers. Results are compared field by field in arrival order. The run
// steps through several limit settings: defaults, wide limits with a small
// address space, an empty slave window with extreme quantities, random
// settings, and defaults again without idling.
// ----------------------------------------------------------------------------
`default_nettype none

module modbus_request_checker_unit_tb import mrc_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT = 200000;
  localparam int LONG_HOLD   = 300;
  localparam cfg_t LIMITS_DEFAULT = '{16'd65535, 8'd1, 8'd247, 16'd1,
                                      16'd2000, 16'd125, 16'd1968, 16'd123};

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_idx;
  logic [CFG_DATA_W-1:0] cfg_data;
  logic                  in_valid;
  logic                  in_stall;
  req_t                  in_req;
  logic                  out_valid;
  logic                  out_stall;
  rsp_t                  out_rsp;

  // Limits as the block should currently hold them
  cfg_t limits = LIMITS_DEFAULT;

  req_t pending_requests[$];
  rsp_t awaited_outcomes[$];

  logic  req_taken = 1'b0;
  bit    quiet = 1'b0;
  int    hold_requests = 0;
  int    holds_served = 0;
  int    hold_left = 0;
  int    stall_left = 0;
  int    recv_span = 0;
  int    recv_odds = 0;
  int    gap_left = 0;
  int    send_span = 0;
  int    send_odds = 0;
  int    cycles = 0;
  int    failures = 0;
  int    checked = 0;
  int    settings_run = 1;
  bit [31:0] outcomes_seen = '0;

  modbus_request_checker_unit u_top (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_data_i  (cfg_data),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_req_i    (in_req),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_rsp_o   (out_rsp)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Range end start + count - 1, taken without wrap
  function automatic bit span_fits(int start, int count);
    return count != 0 && (start + count - 1) <= limits.max_address;
  endfunction

  // First rule the request breaks under the current limits
  function automatic err_e first_failing_rule(req_t r);
    int len;
    int qty;
    int bc;
    len = int'(r.data_length);
    qty = int'(r.quantity_or_value);
    bc  = int'(r.byte_count);
    if (r.rtu_mode && (r.slave_id < limits.min_slave_id ||
                       r.slave_id > limits.max_slave_id)) return ERR_SLAVE_ID;
    if (len > MAX_PDU_DATA) return ERR_PDU_LEN;
    case (r.function_code)
      FC_READ_COILS, FC_READ_DISCRETE, FC_READ_HOLDING, FC_READ_INPUT: begin
        if (len != 4) return ERR_RD_LEN;
        if (qty < limits.min_quantity) return ERR_RD_QTY_MIN;
        if (!span_fits(int'(r.start_address), qty)) return ERR_RD_RANGE;
        if (r.function_code <= FC_READ_DISCRETE) begin
          if (qty > limits.max_read_bits) return ERR_RD_BITS_MAX;
        end else begin
          if (qty > limits.max_read_registers) return ERR_RD_REGS_MAX;
        end
      end
      FC_WRITE_COIL, FC_WRITE_REG: begin
        if (len != 4) return ERR_WS_LEN;
        if (!span_fits(int'(r.start_address), 1)) return ERR_WS_ADDR;
        if (r.function_code == FC_WRITE_COIL && r.quantity_or_value != COIL_OFF &&
            r.quantity_or_value != COIL_ON) return ERR_WS_COIL_VAL;
      end
      FC_WRITE_COILS, FC_WRITE_REGS: begin
        if (len < 5) return ERR_WM_LEN;
        if (qty < limits.min_quantity) return ERR_WM_QTY_MIN;
        if (!span_fits(int'(r.start_address), qty)) return ERR_WM_RANGE;
        if (bc != len - 5) return ERR_WM_BC_LEN;
        if (r.function_code == FC_WRITE_COILS) begin
          if (qty > limits.max_write_coils) return ERR_WM_COILS_MAX;
          if (bc != (qty + 7) / 8) return ERR_WM_COIL_BC;
        end else begin
          if (qty > limits.max_write_registers) return ERR_WM_REGS_MAX;
          if (bc != qty * 2) return ERR_WM_REG_BC;
        end
      end
      default: return ERR_FUNC;
    endcase
    if (2 + len > MAX_MBAP_LENGTH) return ERR_MBAP_LEN;
    if (4 + len > ADU_LIMIT) return ERR_ADU_LEN;
    return ERR_OK;
  endfunction

  // Mostly well-formed requests with random content, some broken, some noise
  function automatic req_t compose_request();
    logic [95:0] noise;
    req_t r;
    int qty;
    int cap;
    int bc;
    noise = {$urandom, $urandom, $urandom};
    r = noise[$bits(req_t)-1:0];
    if ($urandom_range(0, 99) < 12) return r;
    r.slave_id = 8'($urandom_range(limits.min_slave_id, limits.max_slave_id));
    case ($urandom_range(0, 8))
      0: r.function_code = FC_READ_COILS;
      1: r.function_code = FC_READ_DISCRETE;
      2: r.function_code = FC_READ_HOLDING;
      3: r.function_code = FC_READ_INPUT;
      4: r.function_code = FC_WRITE_COIL;
      5: r.function_code = FC_WRITE_REG;
      6: r.function_code = FC_WRITE_COILS;
      7: r.function_code = FC_WRITE_REGS;
      default: ;
    endcase
    case (r.function_code)
      FC_READ_COILS, FC_READ_DISCRETE, FC_READ_HOLDING, FC_READ_INPUT: begin
        cap = (r.function_code <= FC_READ_DISCRETE) ? int'(limits.max_read_bits)
                                                     : int'(limits.max_read_registers);
        qty = $urandom_range(limits.min_quantity, cap);
        r.data_length = 10'd4;
        r.quantity_or_value = qty[15:0];
        if (qty >= 1 && qty - 1 <= limits.max_address)
          r.start_address = 16'($urandom_range(0, limits.max_address - qty + 1));
      end
      FC_WRITE_COIL, FC_WRITE_REG: begin
        r.data_length = 10'd4;
        r.start_address = 16'($urandom_range(0, limits.max_address));
        if (r.function_code == FC_WRITE_COIL && $urandom_range(0, 3) != 0)
          r.quantity_or_value = $urandom_range(0, 1) ? COIL_ON : COIL_OFF;
      end
      FC_WRITE_COILS, FC_WRITE_REGS: begin
        // keep the byte count within one PDU
        if (r.function_code == FC_WRITE_COILS)
          cap = (limits.max_write_coils < 1976) ? limits.max_write_coils : 1976;
        else
          cap = (limits.max_write_registers < 123) ? limits.max_write_registers : 123;
        qty = $urandom_range(limits.min_quantity, cap);
        bc = (r.function_code == FC_WRITE_COILS) ? (qty + 7) / 8 : qty * 2;
        if (bc <= 247) r.byte_count = bc[7:0];
        r.data_length = r.byte_count + 10'd5;
        r.quantity_or_value = qty[15:0];
        if (qty >= 1 && qty - 1 <= limits.max_address)
          r.start_address = 16'($urandom_range(0, limits.max_address - qty + 1));
      end
      default: ;
    endcase
    // break one field now and then
    if ($urandom_range(0, 3) == 0) begin
      case ($urandom_range(0, 4))
        0: r.data_length = 10'($urandom_range(0, 10));
        1: r.quantity_or_value = r.quantity_or_value + 16'($urandom_range(1, 3)) - 16'd2;
        2: r.start_address = 16'($urandom);
        3: r.byte_count = r.byte_count ^ (8'd1 << $urandom_range(0, 7));
        default: r.slave_id = 8'($urandom);
      endcase
    end
    return r;
  endfunction

  function automatic void queue_request(logic rtu, logic [7:0] sid, logic [7:0] fc,
                                        logic [9:0] len, logic [15:0] start,
                                        logic [15:0] qv, logic [7:0] bc);
    req_t r;
    r = '{rtu, sid, fc, len, start, qv, bc};
    pending_requests.push_back(r);
  endfunction

  function automatic void queue_random(int count);
    repeat (count) pending_requests.push_back(compose_request());
  endfunction

  // Wait until every item has gone through and no result is outstanding
  task automatic drain();
    while (pending_requests.size() != 0 || in_valid || awaited_outcomes.size() != 0)
      @(posedge clk);
    repeat (4) @(negedge clk);
  endtask

  // Write all eight limit registers; only called while the block is idle
  task automatic load_limits(cfg_t v);
    logic [CFG_DATA_W-1:0] word;
    cfg_idx_e idx;
    for (int i = 0; i < 8; i++) begin
      idx = cfg_idx_e'(i);
      case (idx)
        CFG_MAX_ADDRESS:  word = v.max_address;
        CFG_MIN_SLAVE_ID: word = {8'($urandom), v.min_slave_id};
        CFG_MAX_SLAVE_ID: word = {8'($urandom), v.max_slave_id};
        CFG_MIN_QUANTITY: word = v.min_quantity;
        CFG_MAX_RD_BITS:  word = v.max_read_bits;
        CFG_MAX_RD_REGS:  word = v.max_read_registers;
        CFG_MAX_WR_COILS: word = v.max_write_coils;
        default:          word = v.max_write_registers;
      endcase
      @(negedge clk);
      cfg_we   <= 1'b1;
      cfg_idx  <= idx;
      cfg_data <= word;
    end
    @(negedge clk);
    cfg_we <= 1'b0;
    limits = v;
  endtask

  // Sender: presents the next pending item once the previous one is taken
  always @(negedge clk) begin
    if (!in_valid || req_taken) begin
      if (send_span == 0) begin
        send_span = $urandom_range(20, 120);
        send_odds = $urandom_range(0, 2) * 10;
      end
      send_span--;
      if (gap_left == 0 && !quiet && $urandom_range(0, 99) < send_odds)
        gap_left = $urandom_range(1, 6);
      if (gap_left > 0) begin
        gap_left--;
        in_valid <= 1'b0;
      end else if (pending_requests.size() != 0) begin
        in_valid <= 1'b1;
        in_req   <= pending_requests.pop_front();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Receiver: random stall bursts plus an occasional long hold-off
  always @(negedge clk) begin
    if (holds_served != hold_requests) begin
      holds_served = hold_requests;
      hold_left = LONG_HOLD;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      if (recv_span == 0) begin
        recv_span = $urandom_range(20, 120);
        recv_odds = $urandom_range(0, 2) * 8;
      end
      recv_span--;
      if (stall_left == 0 && !quiet && $urandom_range(0, 99) < recv_odds)
        stall_left = $urandom_range(1, 6);
      if (stall_left > 0) begin
        stall_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // Monitor: predict on each accepted item, check each accepted result
  always @(posedge clk) begin
    rsp_t want;
    err_e code;
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("%0t: timeout after %0d cycles", $time, cycles);
      $display("Test completed with failures");
      $finish;
    end else begin
      req_taken <= in_valid && !in_stall;
      if (rst_n) begin
        if (in_valid && !in_stall) begin
          code = first_failing_rule(in_req);
          want.valid_res  = (code == ERR_OK);
          want.error_code = code;
          awaited_outcomes.push_back(want);
          outcomes_seen[code] = 1'b1;
        end
        if (out_valid && !out_stall) begin
          if (awaited_outcomes.size() == 0) begin
            $display("%0t: unexpected result, expected none, actual valid_res %0d code %0d",
                     $time, out_rsp.valid_res, out_rsp.error_code);
            failures++;
          end else begin
            want = awaited_outcomes.pop_front();
            checked++;
            if (out_rsp.valid_res !== want.valid_res) begin
              $display("%0t: valid_res mismatch, expected %0d, actual %0d",
                       $time, want.valid_res, out_rsp.valid_res);
              failures++;
            end
            if (out_rsp.error_code !== want.error_code) begin
              $display("%0t: error_code mismatch, expected %0d, actual %0d",
                       $time, want.error_code, out_rsp.error_code);
              failures++;
            end
          end
        end
      end
    end
  end

  // Stimulus sequence
  initial begin
    cfg_t setting;
    rst_n     = 1'b0;
    cfg_we    = 1'b0;
    cfg_idx   = '0;
    cfg_data  = '0;
    in_valid  = 1'b0;
    in_req    = '0;
    out_stall = 1'b0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    repeat (2) @(negedge clk);

    // Defaults after reset: most code paths and field extremes
    queue_request(0, 8'd0,   FC_READ_COILS,    10'd4,   16'd0,     16'd1,     8'd0);
    queue_request(1, 8'd1,   FC_READ_DISCRETE, 10'd4,   16'd0,     16'd2000,  8'hFF);
    queue_request(1, 8'd247, FC_READ_HOLDING,  10'd4,   16'd65411, 16'd125,   8'd0);
    queue_request(1, 8'd248, FC_READ_INPUT,    10'd4,   16'd0,     16'd1,     8'd0);
    queue_request(1, 8'd0,   FC_READ_INPUT,    10'd4,   16'd0,     16'd1,     8'd0);
    queue_request(0, 8'd5,   FC_READ_INPUT,    10'd4,   16'd0,     16'd126,   8'd0);
    queue_request(0, 8'd5,   FC_READ_COILS,    10'd4,   16'd0,     16'd2001,  8'd0);
    queue_request(0, 8'd5,   FC_READ_HOLDING,  10'd4,   16'd0,     16'd0,     8'd0);
    queue_request(0, 8'd5,   FC_READ_DISCRETE, 10'd4,   16'hFFFF,  16'd2,     8'd0);
    queue_request(0, 8'd5,   FC_READ_COILS,    10'd5,   16'd0,     16'd1,     8'd0);
    queue_request(0, 8'd5,   FC_WRITE_COIL,    10'd4,   16'hFFFF,  COIL_ON,   8'd0);
    queue_request(0, 8'd5,   FC_WRITE_COIL,    10'd4,   16'd0,     COIL_OFF,  8'd0);
    queue_request(0, 8'd5,   FC_WRITE_COIL,    10'd4,   16'd0,     16'h1234,  8'd0);
    queue_request(0, 8'd5,   FC_WRITE_REG,     10'd4,   16'd0,     16'hFFFF,  8'hFF);
    queue_request(0, 8'd5,   FC_WRITE_REG,     10'd3,   16'd0,     16'd0,     8'd0);
    queue_request(0, 8'd5,   FC_WRITE_COILS,   10'd251, 16'd0,     16'd1968,  8'd246);
    queue_request(0, 8'd5,   FC_WRITE_COILS,   10'd252, 16'd0,     16'd1969,  8'd247);
    queue_request(0, 8'd5,   FC_WRITE_COILS,   10'd7,   16'd0,     16'd8,     8'd2);
    queue_request(0, 8'd5,   FC_WRITE_REGS,    10'd251, 16'd0,     16'd123,   8'd246);
    queue_request(0, 8'd5,   FC_WRITE_REGS,    10'd253, 16'd0,     16'd124,   8'd248);
    queue_request(0, 8'd5,   FC_WRITE_REGS,    10'd8,   16'd0,     16'd2,     8'd4);
    queue_request(0, 8'd5,   FC_WRITE_REGS,    10'd10,  16'd0,     16'd3,     8'd5);
    queue_request(0, 8'd5,   FC_WRITE_REGS,    10'd7,   16'hFFFF,  16'd2,     8'd2);
    queue_request(0, 8'd5,   FC_WRITE_COILS,   10'd4,   16'd0,     16'd1,     8'd0);
    queue_request(0, 8'd5,   FC_WRITE_REGS,    10'd6,   16'd0,     16'd0,     8'd1);
    queue_request(0, 8'hFF,  8'hFF,            10'h3FF, 16'hFFFF,  16'hFFFF,  8'hFF);
    queue_request(0, 8'd5,   8'd0,             10'd4,   16'd0,     16'd1,     8'd0);
    queue_random(150);
    // long receiver hold-off while the sender keeps offering items
    hold_requests++;
    queue_random(150);
    drain();

    // Small address space, zero quantity allowed, open slave window, wide caps
    setting = '{16'd100, 8'd0, 8'd255, 16'd0, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF};
    load_limits(setting);
    settings_run++;
    queue_request(0, 8'd5,   FC_READ_COILS,  10'd4, 16'd10,  16'd0, 8'd0);
    queue_request(0, 8'd5,   FC_WRITE_COILS, 10'd5, 16'd10,  16'd0, 8'd0);
    queue_request(0, 8'd5,   FC_WRITE_REG,   10'd4, 16'd101, 16'd0, 8'd0);
    queue_request(0, 8'd5,   FC_WRITE_REG,   10'd4, 16'd100, 16'd0, 8'd0);
    queue_request(0, 8'd5,   FC_READ_HOLDING, 10'd4, 16'd99, 16'd2, 8'd0);
    queue_request(1, 8'd0,   FC_READ_INPUT,  10'd4, 16'd0,   16'd1, 8'd0);
    queue_request(1, 8'd255, FC_READ_INPUT,  10'd4, 16'd0,   16'd1, 8'd0);
    queue_random(200);
    drain();

    // Empty slave window, largest minimum quantity, zero caps
    setting = '{16'hFFFF, 8'd200, 8'd10, 16'hFFFF, 16'd0, 16'd0, 16'd0, 16'd0};
    load_limits(setting);
    settings_run++;
    queue_request(1, 8'd100, FC_READ_COILS,  10'd4, 16'd0, 16'd1,     8'd0);
    queue_request(1, 8'd200, FC_READ_COILS,  10'd4, 16'd0, 16'd1,     8'd0);
    queue_request(0, 8'd100, FC_READ_COILS,  10'd4, 16'd0, 16'hFFFF,  8'd0);
    queue_request(0, 8'd1,   FC_WRITE_REGS,  10'd9, 16'd0, 16'hFFFF,  8'd4);
    queue_request(0, 8'd1,   FC_WRITE_COILS, 10'd9, 16'd0, 16'hFFFF,  8'd4);
    queue_random(150);
    drain();

    // Random limit settings
    repeat (2) begin
      setting.max_address         = 16'($urandom);
      setting.min_slave_id        = 8'($urandom);
      setting.max_slave_id        = 8'($urandom);
      setting.min_quantity        = 16'($urandom_range(0, 4));
      setting.max_read_bits       = 16'($urandom_range(0, 3000));
      setting.max_read_registers  = 16'($urandom_range(0, 200));
      setting.max_write_coils     = 16'($urandom_range(0, 3000));
      setting.max_write_registers = 16'($urandom_range(0, 200));
      load_limits(setting);
      settings_run++;
      queue_random(100);
      drain();
    end

    // Back to defaults, both sides at full rate
    load_limits(LIMITS_DEFAULT);
    settings_run++;
    quiet = 1'b1;
    queue_random(150);
    drain();
    repeat (10) @(negedge clk);

    if (awaited_outcomes.size() != 0) begin
      $display("%0t: %0d results never arrived", $time, awaited_outcomes.size());
      failures++;
    end
    $display("Checked %0d request results across %0d limit settings,", checked, settings_run);
    $display("%0d of 22 outcome codes exercised, %0d mismatches.",
             $countones(outcomes_seen), failures);
    if (failures == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

`default_nettype wire
